/* sv/bcpg_pkg.sv */
package bcpg_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int MAX_STEPS   = 63;
    localparam int STEP_W      = $clog2(MAX_STEPS + 1);
    localparam int FRAC_BITS   = 24;
    localparam int WT_W        = FRAC_BITS + 1;
    localparam int WT_PROD_W   = 2 * FRAC_BITS + 2;
    localparam int MUL_A_W     = ((COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2) + 1;
    localparam int PROD_W      = MUL_A_W + WT_W + 1;
    localparam int ACC_W       = COORD_WIDTH + FRAC_BITS + 1;
    localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);
    localparam int IN_DATA_W   = ((8 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((2 * COORD_WIDTH + STEP_W + 7) / 8) * 8;
    localparam int STEPS_RESET = 20;

    localparam logic [WT_W-1:0] ONE_Q = WT_W'(1) << FRAC_BITS;

    typedef logic [WT_W-1:0]        wt_t;
    typedef logic [STEP_W-1:0]      step_t;
    typedef logic [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic  done;
        wt_t   quo;
        step_t rem;
    } bcpg_div_res_t;

    function automatic wt_t round_wt(input logic [WT_PROD_W-1:0] p);
        logic [WT_PROD_W-1:0] s;
        s = p + (WT_PROD_W'(1) << (FRAC_BITS - 1));
        return s[FRAC_BITS +: WT_W];
    endfunction

endpackage

/* sv/bcpg_div.sv */
module bcpg_div
    import bcpg_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  step_t         divisor,
    output bcpg_div_res_t res
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    step_t                rem_reg;
    step_t                rem_next;
    wt_t                  quo_reg;
    logic [STEP_W:0]      shifted;
    logic                 fits;

    always_comb begin
        shifted  = {rem_reg, cnt_reg == DIV_CNT_W'(FRAC_BITS)};
        fits     = shifted >= {1'b0, divisor};
        rem_next = fits ? STEP_W'(shifted - {1'b0, divisor}) : shifted[STEP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= DIV_CNT_W'(FRAC_BITS);
            rem_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[WT_W-2:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
    assign res.rem  = rem_reg;

endmodule

/* sv/bcpg_mul.sv */
module bcpg_mul
    import bcpg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [MUL_A_W-1:0] a,
    input  wt_t                      b,
    output logic signed [PROD_W-1:0]  p
);

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * $signed({1'b0, b});
        end
    end

    assign p = p_reg;

endmodule

/* sv/cubic_bezier_point_generator.sv */
// After a command word is taken, the divider sets up the step increment; each point then
// steps through the weight, x blend, y blend and output phases. A new command is taken
// only once the last point of a curve is loaded for output. One shared multiplier serves
// all weight and blend products; a point stalls while the output is full.
// Reset: synchronous, active low; clears the sequencer and output valid, sets steps to 20.
module cubic_bezier_point_generator
    import bcpg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  step_t                 cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, finish_x, finish_y
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // point_x, point_y, step_index, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    localparam logic [3:0] PH_TT  = 4'd0;
    localparam logic [3:0] PH_UU  = 4'd1;
    localparam logic [3:0] PH_W3  = 4'd2;
    localparam logic [3:0] PH_W2  = 4'd3;
    localparam logic [3:0] PH_W1  = 4'd4;
    localparam logic [3:0] PH_X3  = 4'd5;
    localparam logic [3:0] PH_X2  = 4'd6;
    localparam logic [3:0] PH_X1  = 4'd7;
    localparam logic [3:0] PH_X0  = 4'd8;
    localparam logic [3:0] PH_Y3  = 4'd9;
    localparam logic [3:0] PH_Y2  = 4'd10;
    localparam logic [3:0] PH_Y1  = 4'd11;
    localparam logic [3:0] PH_Y0  = 4'd12;
    localparam logic [3:0] PH_OUT = 4'd13;

    logic [1:0] state_reg;
    logic [3:0] phase_reg;
    step_t      steps_reg;
    step_t      n_reg;
    step_t      i_reg;
    step_t      r_reg;
    wt_t        t_reg, u_reg, tt_reg, uu_reg;
    wt_t        w0_reg, w1_reg, w2_reg, w3_reg;
    coord_t     px_reg [4];
    coord_t     py_reg [4];
    coord_t     x_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic       out_valid_reg;
    coord_t     out_x_reg, out_y_reg;
    step_t      out_idx_reg;
    logic       out_last_reg;

    bcpg_div_res_t            div_res;
    logic                     s_accept;
    logic                     out_free;
    logic                     advance;
    logic                     last_pt;
    logic [MUL_A_W-1:0]       a_raw;
    wt_t                      b_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_acc;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  coord_rnd;
    coord_t                   coord_val;
    wt_t                      w_rnd;
    logic [WT_W:0]            tt3, uu3;
    logic [STEP_W:0]          r_sum;
    logic                     r_carry;
    step_t                    r_next;

    assign s_tready = state_reg == ST_IDLE;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = state_reg == ST_RUN && (phase_reg != PH_OUT || out_free);
    assign last_pt  = i_reg == n_reg;

    bcpg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_accept),
        .divisor (n_reg),
        .res     (div_res)
    );

    always_comb begin
        tt3 = {tt_reg, 1'b0} + (WT_W + 1)'(tt_reg);
        uu3 = {uu_reg, 1'b0} + (WT_W + 1)'(uu_reg);
        unique case (phase_reg)
            PH_TT:   begin a_raw = MUL_A_W'(t_reg);              b_op = t_reg;  end
            PH_UU:   begin a_raw = MUL_A_W'(u_reg);              b_op = u_reg;  end
            PH_W3:   begin a_raw = MUL_A_W'(tt_reg);             b_op = t_reg;  end
            PH_W2:   begin a_raw = MUL_A_W'(tt3);                b_op = u_reg;  end
            PH_W1:   begin a_raw = MUL_A_W'(uu3);                b_op = t_reg;  end
            PH_X3:   begin a_raw = MUL_A_W'($signed(px_reg[3])); b_op = w3_reg; end
            PH_X2:   begin a_raw = MUL_A_W'($signed(px_reg[2])); b_op = w2_reg; end
            PH_X1:   begin a_raw = MUL_A_W'($signed(px_reg[1])); b_op = w1_reg; end
            PH_X0:   begin a_raw = MUL_A_W'($signed(px_reg[0])); b_op = w0_reg; end
            PH_Y3:   begin a_raw = MUL_A_W'($signed(py_reg[3])); b_op = w3_reg; end
            PH_Y2:   begin a_raw = MUL_A_W'($signed(py_reg[2])); b_op = w2_reg; end
            PH_Y1:   begin a_raw = MUL_A_W'($signed(py_reg[1])); b_op = w1_reg; end
            PH_Y0:   begin a_raw = MUL_A_W'($signed(py_reg[0])); b_op = w0_reg; end
            default: begin a_raw = '0;                           b_op = '0;     end
        endcase
    end

    bcpg_mul u_mul (
        .aclk (aclk),
        .en   (advance && phase_reg != PH_OUT),
        .a    ($signed(a_raw)),
        .b    (b_op),
        .p    (prod)
    );

    always_comb begin
        prod_acc  = prod[ACC_W-1:0];
        acc_sum   = acc_reg + prod_acc;
        coord_rnd = acc_sum + (ACC_W'(1) << (FRAC_BITS - 1));
        coord_val = coord_rnd[FRAC_BITS +: COORD_WIDTH];
        w_rnd     = round_wt(prod[WT_PROD_W-1:0]);
        r_sum     = {1'b0, r_reg} + {1'b0, div_res.rem};
        r_carry   = r_sum >= {1'b0, n_reg};
        r_next    = r_carry ? STEP_W'(r_sum - {1'b0, n_reg}) : r_sum[STEP_W-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_TT;
            steps_reg     <= STEP_W'(STEPS_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                steps_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_res.done) begin
                        state_reg <= ST_RUN;
                        phase_reg <= PH_TT;
                    end
                end
                ST_RUN: begin
                    if (advance) begin
                        if (phase_reg == PH_OUT) begin
                            phase_reg <= PH_TT;
                            if (last_pt) begin
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            phase_reg <= phase_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (advance && phase_reg == PH_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            n_reg <= (steps_reg == '0) ? STEP_W'(1) : steps_reg;
            for (int k = 0; k < 4; k++) begin
                px_reg[k] <= s_tdata[2 * k * COORD_WIDTH +: COORD_WIDTH];
                py_reg[k] <= s_tdata[(2 * k + 1) * COORD_WIDTH +: COORD_WIDTH];
            end
        end
        if (state_reg == ST_DIV && div_res.done) begin
            t_reg <= '0;
            i_reg <= '0;
            r_reg <= n_reg >> 1;
        end
        if (advance) begin
            case (phase_reg)
                PH_TT: u_reg  <= ONE_Q - t_reg;
                PH_UU: tt_reg <= w_rnd;
                PH_W3: uu_reg <= w_rnd;
                PH_W2: w3_reg <= w_rnd;
                PH_W1: w2_reg <= w_rnd;
                PH_X3: w1_reg <= w_rnd;
                PH_X2: begin
                    acc_reg <= prod_acc;
                    w0_reg  <= ONE_Q - w1_reg - w2_reg - w3_reg;
                end
                PH_X1, PH_X0, PH_Y1, PH_Y0: acc_reg <= acc_sum;
                PH_Y3: x_reg   <= coord_val;
                PH_Y2: acc_reg <= prod_acc;
                PH_OUT: begin
                    out_x_reg    <= x_reg;
                    out_y_reg    <= coord_val;
                    out_idx_reg  <= i_reg;
                    out_last_reg <= last_pt;
                    t_reg        <= t_reg + div_res.quo + WT_W'(r_carry);
                    r_reg        <= r_next;
                    i_reg        <= i_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DATA_W'({out_idx_reg, out_y_reg, out_x_reg});

endmodule

/* sv/bcpg_chk.sv */
module bcpg_chk
    import bcpg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

    a_last_not_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[2 * COORD_WIDTH +: STEP_W] != '0)
        else $error("last flag on first point");

endmodule

bind cubic_bezier_point_generator bcpg_chk u_bcpg_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* tb/tb_cubic_bezier_point_generator.sv */
module tb_cubic_bezier_point_generator;
    import bcpg_pkg::*;

    typedef struct packed {
        logic   last;
        step_t  idx;
        coord_t y;
        coord_t x;
    } curve_point_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    step_t                 cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, finish_x, finish_y
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // point_x, point_y, step_index, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    curve_point_t pending_points[$];
    step_t        steps_setting;
    logic         no_idle;
    int           mismatches;
    int           curves_sent;
    int           points_checked;
    int           settings_used;

    cubic_bezier_point_generator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint unsigned q24_round_mul(input longint unsigned a,
                                                      input longint unsigned b);
        return (a * b + 64'd8388608) >> FRAC_BITS;
    endfunction

    // axis 0 selects x, 1 selects y
    function automatic coord_t blend_coord(input logic [IN_DATA_W-1:0] word, input int axis,
                                           input longint w0, input longint w1,
                                           input longint w2, input longint w3);
        longint acc;
        longint cv;
        logic signed [COORD_WIDTH-1:0] c;
        longint w[4];
        w[0] = w0;
        w[1] = w1;
        w[2] = w2;
        w[3] = w3;
        acc = 0;
        for (int k = 0; k < 4; k++) begin
            c = word[(2 * k + axis) * COORD_WIDTH +: COORD_WIDTH];
            cv = c;
            acc = acc + w[k] * cv;
        end
        acc = (acc + 64'sd8388608) >>> FRAC_BITS;
        return acc[COORD_WIDTH-1:0];
    endfunction

    function automatic void predict_curve_points(input logic [IN_DATA_W-1:0] word);
        longint unsigned n;
        longint unsigned t;
        longint unsigned u;
        longint unsigned tt;
        longint unsigned uu;
        longint unsigned w0, w1, w2, w3;
        curve_point_t p;
        n = steps_setting;
        if (n == 0) n = 1;
        if (n > MAX_STEPS) n = MAX_STEPS;
        for (longint unsigned i = 0; i <= n; i++) begin
            t  = ((i << FRAC_BITS) + n / 2) / n;
            u  = (64'd1 << FRAC_BITS) - t;
            tt = q24_round_mul(t, t);
            uu = q24_round_mul(u, u);
            w3 = q24_round_mul(tt, t);
            w2 = q24_round_mul(3 * tt, u);
            w1 = q24_round_mul(3 * uu, t);
            w0 = (64'd1 << FRAC_BITS) - w1 - w2 - w3;
            p.x    = blend_coord(word, 0, w0, w1, w2, w3);
            p.y    = blend_coord(word, 1, w0, w1, w2, w3);
            p.idx  = i[STEP_W-1:0];
            p.last = (i == n);
            pending_points = {pending_points, p};
        end
    endfunction

    function automatic logic idle_roll();
        return !no_idle && ($urandom_range(0, 99) < 34);
    endfunction

    function automatic coord_t rand_coord(input int mode);
        coord_t v;
        case (mode)
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                v = v ^ $urandom_range(0, 32'hFFFF);
            end
        endcase
        return v;
    endfunction

    // x takes the given value, y its bitwise complement
    function automatic logic [IN_DATA_W-1:0] curve_of(input coord_t p0, input coord_t c1,
                                                      input coord_t c2, input coord_t p3);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[0*COORD_WIDTH +: COORD_WIDTH] = p0;
        word[1*COORD_WIDTH +: COORD_WIDTH] = ~p0;
        word[2*COORD_WIDTH +: COORD_WIDTH] = c1;
        word[3*COORD_WIDTH +: COORD_WIDTH] = ~c1;
        word[4*COORD_WIDTH +: COORD_WIDTH] = c2;
        word[5*COORD_WIDTH +: COORD_WIDTH] = ~c2;
        word[6*COORD_WIDTH +: COORD_WIDTH] = p3;
        word[7*COORD_WIDTH +: COORD_WIDTH] = ~p3;
        return word;
    endfunction

    task automatic send_curve(input logic [IN_DATA_W-1:0] word);
        @(negedge aclk);
        while (idle_roll()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        predict_curve_points(word);
        curves_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_curve();
        logic [IN_DATA_W-1:0] word;
        int mode;
        mode = $urandom_range(0, 3);
        for (int k = 0; k < 8; k++)
            word[k * COORD_WIDTH +: COORD_WIDTH] = rand_coord(($urandom_range(0, 4) == 0) ?
                                                              $urandom_range(0, 3) : mode);
        send_curve(word);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_steps(input step_t value);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        steps_setting = value;
        settings_used++;
    endtask

    task automatic send_extreme_set();
        send_curve(curve_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_curve(curve_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_curve(curve_of(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_curve(curve_of(32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000));
    endtask

    task automatic test_reset_default();
        send_extreme_set();
        send_curve(curve_of(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_curve(curve_of(32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000));
    endtask

    task automatic test_zero_steps();
        write_steps(step_t'(0));
        send_extreme_set();
        send_random_curve();
    endtask

    task automatic test_single_interval();
        write_steps(step_t'(1));
        send_curve(curve_of(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_random_curve();
        send_random_curve();
    endtask

    task automatic test_max_steps();
        write_steps(step_t'(MAX_STEPS));
        send_extreme_set();
        send_random_curve();
        write_steps(step_t'(2));
        send_curve(curve_of(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_random_curve();
    endtask

    task automatic test_back_to_back();
        write_steps(step_t'($urandom_range(1, 6)));
        no_idle = 1'b1;
        repeat (40) send_random_curve();
        drain();
        no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        int roll;
        step_t s;
        for (int ph = 0; ph < 9; ph++) begin
            roll = $urandom_range(0, 99);
            if (ph == 0)        s = step_t'(MAX_STEPS);
            else if (roll < 8)  s = step_t'(0);
            else if (roll < 75) s = step_t'($urandom_range(1, 8));
            else if (roll < 92) s = step_t'($urandom_range(9, 40));
            else                s = step_t'($urandom_range(41, MAX_STEPS));
            write_steps(s);
            repeat ((ph == 0) ? 8 : 34) send_random_curve();
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 34);
    end

    always @(posedge aclk) begin
        curve_point_t got;
        curve_point_t exp_pt;
        if (aresetn && m_tvalid && m_tready) begin
            got.x    = m_tdata[0 +: COORD_WIDTH];
            got.y    = m_tdata[COORD_WIDTH +: COORD_WIDTH];
            got.idx  = m_tdata[2 * COORD_WIDTH +: STEP_W];
            got.last = m_tlast;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point: x=%h y=%h idx=%0d last=%b",
                             got.x, got.y, got.idx, got.last);
            end else begin
                exp_pt = pending_points.pop_front();
                points_checked++;
                if (got.x !== exp_pt.x || got.y !== exp_pt.y ||
                    got.idx !== exp_pt.idx || got.last !== exp_pt.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("point mismatch: exp x=%h y=%h idx=%0d last=%b,",
                                 exp_pt.x, exp_pt.y, exp_pt.idx, exp_pt.last);
                        $display("                got x=%h y=%h idx=%0d last=%b",
                                 got.x, got.y, got.idx, got.last);
                    end
                end
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        no_idle        = 1'b0;
        mismatches     = 0;
        curves_sent    = 0;
        points_checked = 0;
        settings_used  = 1;
        steps_setting  = step_t'(STEPS_RESET);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_default();
        test_zero_steps();
        test_single_interval();
        test_max_steps();
        test_back_to_back();
        test_random_phases();
        drain();

        $display("Covered %0d curve commands and %0d points over %0d step settings,",
                 curves_sent, points_checked, settings_used);
        $display("including zero and maximum steps, extreme coordinates and back-to-back words.");
        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d points never arrived",
                     mismatches, pending_points.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
